@@ sv/multi_role_refcount_block_pool_defines.svh @@
// Assertion macros used by the block pool checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef MULTI_ROLE_REFCOUNT_BLOCK_POOL_DEFINES_SVH
`define MULTI_ROLE_REFCOUNT_BLOCK_POOL_DEFINES_SVH

// same-cycle implication
`define MRRBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRRBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mrrbp_pkg.sv @@
// Shared types and constants of the reference-counted block pool.
// No dependencies.
package mrrbp_pkg;

  localparam int POOL_SIZE  = 256;
  localparam int COUNT_BITS = 16;
  localparam int NUM_ROLES  = 4;
  localparam int BLK_W      = 8;
  localparam int CNT_W      = 16;
  localparam int IDX_W      = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int DEPTH_W    = $clog2(POOL_SIZE + 1);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [DEPTH_W-1:0]    depth_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_ADD_REF   = 2'd1,
    OP_RELEASE   = 2'd2,
    OP_MARK_PEND = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ROLE_DRAFT   = 2'd0,
    ROLE_TARGET  = 2'd1,
    ROLE_POLICY  = 2'd2,
    ROLE_EVICTOR = 2'd3
  } role_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_EVICTOR_ALLOC = 3'd1,
    ST_OUT_OF_BLOCKS = 3'd2,
    ST_BAD_ID        = 3'd3,
    ST_PENDING       = 3'd4,
    ST_SATURATED     = 3'd5,
    ST_ALREADY_ZERO  = 3'd6,
    ST_UNALLOCATED   = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RELOAD
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [BLK_W-1:0] blk_addr;
    role_e            role;
  } in_req_t;

  typedef struct packed {
    logic [BLK_W-1:0] result_block;
    logic [CNT_W-1:0] new_count;
    status_e          status;
    logic             block_freed;
  } out_rsp_t;

  typedef struct packed {
    logic                     pending;
    count_t [NUM_ROLES-1:0]   cnt;
  } entry_t;

endpackage

@@ sv/mrrbp_cnt_ram.sv @@
// Per-block count memory (pending mark plus four role counts) and in-use bits.
// Depends on mrrbp_pkg.
module mrrbp_cnt_ram import mrrbp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   rd_en_i,
  input  idx_t   rd_addr_i,
  output entry_t rd_data_o,
  output logic   rd_in_use_o,
  input  logic   wr_en_i,
  input  idx_t   wr_addr_i,
  input  entry_t wr_data_i,
  input  logic   use_set_i,
  input  logic   use_clr_i,
  input  idx_t   use_addr_i
);

  entry_t               mem_q [POOL_SIZE];
  entry_t               rd_data_q;
  logic                 rd_in_use_q;
  logic [POOL_SIZE-1:0] in_use_q, in_use_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_comb begin
    in_use_d = in_use_q;
    if (use_set_i) begin
      in_use_d[use_addr_i] = 1'b1;
    end else if (use_clr_i) begin
      in_use_d[use_addr_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= '0;
      rd_in_use_q <= 1'b0;
    end else begin
      in_use_q <= in_use_d;
      if (rd_en_i) begin
        rd_in_use_q <= in_use_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o   = rd_data_q;
  assign rd_in_use_o = rd_in_use_q;

endmodule

@@ sv/mrrbp_free_stack.sv @@
// LIFO of free block numbers in a memory, with depth and low-water mark.
// Depends on mrrbp_pkg. Slots below the low-water mark read back as their own index.
module mrrbp_free_stack import mrrbp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   rd_en_i,
  output idx_t   top_o,
  input  logic   pop_i,
  input  logic   push_i,
  input  idx_t   push_data_i,
  output depth_t depth_o
);

  idx_t   mem_q [POOL_SIZE];
  idx_t   rd_data_q, rd_idx_q;
  logic   rd_fresh_q;
  depth_t depth_q, depth_d, low_q, low_d;
  depth_t top_pos;

  assign top_pos = depth_q - depth_t'(1);

  always_ff @(posedge clk_i) begin
    if (push_i && (depth_q < depth_t'(POOL_SIZE))) begin
      mem_q[depth_q[IDX_W-1:0]] <= push_data_i;
    end
    if (rd_en_i) begin
      rd_data_q  <= mem_q[top_pos[IDX_W-1:0]];
      rd_idx_q   <= top_pos[IDX_W-1:0];
      rd_fresh_q <= (top_pos < low_q);
    end
  end

  always_comb begin
    depth_d = depth_q;
    low_d   = low_q;
    if (pop_i && (depth_q != '0)) begin
      depth_d = top_pos;
      if (top_pos < low_q) begin
        low_d = top_pos;
      end
    end else if (push_i && (depth_q < depth_t'(POOL_SIZE))) begin
      depth_d = depth_q + depth_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= depth_t'(POOL_SIZE);
      low_q   <= depth_t'(POOL_SIZE);
    end else begin
      depth_q <= depth_d;
      low_q   <= low_d;
    end
  end

  assign top_o   = rd_fresh_q ? rd_idx_q : rd_data_q;
  assign depth_o = depth_q;

endmodule

@@ sv/multi_role_refcount_block_pool.sv @@
// Block pool: four per-role reference counts and an evict-pending mark per block,
// one free stack; one request in, one response out. The accept cycle reads the
// block's entry of the count memory and the top of the free stack, the next cycle
// modifies and writes back and loads the response register; a stalled response
// holds the block in that modify step. A non-evictor allocate that finds the stack
// empty first runs an eviction sweep over the count memory, one block per cycle.
// No clearing pass after reset.
// Depends on mrrbp_pkg, mrrbp_cnt_ram and mrrbp_free_stack.
module multi_role_refcount_block_pool import mrrbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  state_e   state_q, state_d;
  in_req_t  req_q;
  out_rsp_t rsp_q, rsp_d;
  logic     out_valid_q, out_valid_d;
  logic     scanned_q, scanned_d;
  logic     sv_q, sv_d;
  idx_t     s_idx_q, s_idx_d;
  depth_t   scan_idx_q, scan_idx_d;

  logic   accept, out_free, load_rsp;
  entry_t rd_entry, wr_entry;
  logic   rd_in_use;
  logic   cr_rd_en, cr_wr_en, use_set, use_clr;
  idx_t   cr_rd_addr, cr_wr_addr, use_addr;
  logic   st_rd_en, st_pop, st_push;
  idx_t   st_top, st_push_data;
  depth_t st_depth;
  idx_t   blk;
  count_t cur;
  logic   oth_zero, bad_id;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign blk      = req_q.blk_addr[IDX_W-1:0];
  assign cur      = rd_entry.cnt[req_q.role];
  assign oth_zero = (rd_entry.cnt[ROLE_DRAFT] == '0) && (rd_entry.cnt[ROLE_TARGET] == '0)
                    && (rd_entry.cnt[ROLE_POLICY] == '0);
  assign bad_id   = (32'(req_q.blk_addr) >= 32'(POOL_SIZE));

  mrrbp_cnt_ram u_cnt_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (cr_rd_en),
    .rd_addr_i   (cr_rd_addr),
    .rd_data_o   (rd_entry),
    .rd_in_use_o (rd_in_use),
    .wr_en_i     (cr_wr_en),
    .wr_addr_i   (cr_wr_addr),
    .wr_data_i   (wr_entry),
    .use_set_i   (use_set),
    .use_clr_i   (use_clr),
    .use_addr_i  (use_addr)
  );

  mrrbp_free_stack u_free_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (st_rd_en),
    .top_o       (st_top),
    .pop_i       (st_pop),
    .push_i      (st_push),
    .push_data_i (st_push_data),
    .depth_o     (st_depth)
  );

  always_comb begin
    state_d      = state_q;
    scanned_d    = scanned_q;
    sv_d         = 1'b0;
    s_idx_d      = s_idx_q;
    scan_idx_d   = scan_idx_q;
    load_rsp     = 1'b0;
    rsp_d        = '0;
    cr_rd_en     = 1'b0;
    cr_rd_addr   = in_req_i.blk_addr[IDX_W-1:0];
    cr_wr_en     = 1'b0;
    cr_wr_addr   = blk;
    wr_entry     = rd_entry;
    use_set      = 1'b0;
    use_clr      = 1'b0;
    use_addr     = blk;
    st_rd_en     = 1'b0;
    st_pop       = 1'b0;
    st_push      = 1'b0;
    st_push_data = blk;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cr_rd_en  = 1'b1;
          st_rd_en  = 1'b1;
          scanned_d = 1'b0;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_q.op == OP_ALLOC && req_q.role != ROLE_EVICTOR && st_depth == '0
            && !scanned_q) begin
          scan_idx_d = '0;
          state_d    = S_SCAN;
        end else if (out_free) begin
          load_rsp = 1'b1;
          state_d  = S_IDLE;
          if (req_q.op == OP_ALLOC) begin
            if (req_q.role == ROLE_EVICTOR) begin
              rsp_d.status = ST_EVICTOR_ALLOC;
            end else if (st_depth == '0) begin
              rsp_d.status = ST_OUT_OF_BLOCKS;
            end else begin
              st_pop                     = 1'b1;
              cr_wr_en                   = 1'b1;
              cr_wr_addr                 = st_top;
              wr_entry                   = '0;
              wr_entry.cnt[req_q.role]   = count_t'(1);
              use_set                    = 1'b1;
              use_addr                   = st_top;
              rsp_d.result_block         = BLK_W'(st_top);
              rsp_d.new_count            = CNT_W'(1);
              rsp_d.status               = ST_OK;
            end
          end else if (bad_id) begin
            rsp_d.status = ST_BAD_ID;
          end else if (!rd_in_use) begin
            rsp_d.status = ST_UNALLOCATED;
          end else begin
            unique case (req_q.op)
              OP_ADD_REF: begin
                if (rd_entry.pending && req_q.role != ROLE_EVICTOR) begin
                  rsp_d.status = ST_PENDING;
                end else if (cur == COUNT_MAX) begin
                  rsp_d.status    = ST_SATURATED;
                  rsp_d.new_count = CNT_W'(COUNT_MAX);
                end else begin
                  cr_wr_en                 = 1'b1;
                  wr_entry.cnt[req_q.role] = cur + count_t'(1);
                  rsp_d.new_count          = CNT_W'(cur + count_t'(1));
                end
              end
              OP_RELEASE: begin
                if (cur == '0) begin
                  rsp_d.status = ST_ALREADY_ZERO;
                end else begin
                  wr_entry.cnt[req_q.role] = cur - count_t'(1);
                  rsp_d.new_count          = CNT_W'(cur - count_t'(1));
                  if (wr_entry.cnt == '0) begin
                    use_clr           = 1'b1;
                    st_push           = 1'b1;
                    rsp_d.block_freed = 1'b1;
                  end else begin
                    cr_wr_en = 1'b1;
                  end
                end
              end
              OP_MARK_PEND: begin
                if (oth_zero) begin
                  use_clr           = 1'b1;
                  st_push           = 1'b1;
                  rsp_d.block_freed = 1'b1;
                end else begin
                  cr_wr_en         = 1'b1;
                  wr_entry.pending = 1'b1;
                  rsp_d.new_count  = CNT_W'(cur);
                end
              end
              default: begin
                rsp_d.status = ST_OK;
              end
            endcase
          end
        end
      end
      S_SCAN: begin
        if (scan_idx_q != depth_t'(POOL_SIZE)) begin
          cr_rd_en   = 1'b1;
          cr_rd_addr = scan_idx_q[IDX_W-1:0];
          sv_d       = 1'b1;
          s_idx_d    = scan_idx_q[IDX_W-1:0];
          scan_idx_d = scan_idx_q + depth_t'(1);
        end else begin
          state_d = S_RELOAD;
        end
        if (sv_q && rd_in_use && rd_entry.pending && oth_zero
            && rd_entry.cnt[ROLE_EVICTOR] != '0) begin
          use_clr      = 1'b1;
          use_addr     = s_idx_q;
          st_push      = 1'b1;
          st_push_data = s_idx_q;
        end
      end
      S_RELOAD: begin
        st_rd_en  = 1'b1;
        scanned_d = 1'b1;
        state_d   = S_EXEC;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_rsp) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      scanned_q   <= 1'b0;
      sv_q        <= 1'b0;
      scan_idx_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      scanned_q   <= scanned_d;
      sv_q        <= sv_d;
      scan_idx_q  <= scan_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    if (load_rsp) begin
      rsp_q <= rsp_d;
    end
    s_idx_q <= s_idx_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

@@ sv/mrrbp_checker.sv @@
// Port-level checks of the block pool, bound to the top level.
// Depends on mrrbp_pkg and multi_role_refcount_block_pool_defines.svh.
`include "multi_role_refcount_block_pool_defines.svh"

module mrrbp_checker import mrrbp_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_rsp_t out_rsp_o
);

  `MRRBP_ASSERT_NEXT(a_rsp_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o), "response changed while stalled")
  `MRRBP_ASSERT_NEXT(a_one_at_a_time, in_valid_i && !in_stall_o, in_stall_o, "request accepted while one is in flight")
  `MRRBP_ASSERT_NOW(a_refusal_clean, out_valid_o && out_rsp_o.status != ST_OK, out_rsp_o.result_block == '0 && !out_rsp_o.block_freed, "refusal carries a grant or a free")
  `MRRBP_ASSERT_NOW(a_saturated_max, out_valid_o && out_rsp_o.status == ST_SATURATED, out_rsp_o.new_count == CNT_W'(COUNT_MAX), "saturation without maximum count")

endmodule

bind multi_role_refcount_block_pool mrrbp_checker u_mrrbp_checker (.*);

@@ tb/sv/tb_multi_role_refcount_block_pool.sv @@
// Testbench for multi_role_refcount_block_pool: directed and random requests
// checked against a scoreboard that tracks counts, marks and the free stack.
// Depends on mrrbp_pkg and the multi_role_refcount_block_pool RTL.
import mrrbp_pkg::*;

class refcount_scoreboard;
  count_t   cnt [POOL_SIZE][NUM_ROLES];
  bit       pend [POOL_SIZE];
  bit       live [POOL_SIZE];
  idx_t     stack [POOL_SIZE];
  int       depth;
  out_rsp_t expected_q [$];
  int       mismatches;

  function new();
    for (int b = 0; b < POOL_SIZE; b++) begin
      for (int ro = 0; ro < NUM_ROLES; ro++) cnt[b][ro] = '0;
      pend[b]  = 1'b0;
      live[b]  = 1'b0;
      stack[b] = idx_t'(b);
    end
    depth      = POOL_SIZE;
    mismatches = 0;
  endfunction

  function bit others_zero(int b);
    return cnt[b][ROLE_DRAFT] == 0 && cnt[b][ROLE_TARGET] == 0 && cnt[b][ROLE_POLICY] == 0;
  endfunction

  function void free_block(int b);
    for (int ro = 0; ro < NUM_ROLES; ro++) cnt[b][ro] = '0;
    pend[b] = 1'b0;
    live[b] = 1'b0;
    if (depth < POOL_SIZE) begin
      stack[depth] = idx_t'(b);
      depth++;
    end
  endfunction

  function void note_request(in_req_t r);
    out_rsp_t e;
    int       b;
    int       ro;
    int       g;
    e  = '0;
    b  = r.blk_addr;
    ro = r.role;
    if (r.op == OP_ALLOC) begin
      if (r.role == ROLE_EVICTOR) begin
        e.status = ST_EVICTOR_ALLOC;
      end else begin
        if (depth == 0) begin
          for (int s = 0; s < POOL_SIZE; s++)
            if (live[s] && pend[s] && others_zero(s) && cnt[s][ROLE_EVICTOR] != 0)
              free_block(s);
        end
        if (depth == 0) begin
          e.status = ST_OUT_OF_BLOCKS;
        end else begin
          depth--;
          g = stack[depth];
          for (int k = 0; k < NUM_ROLES; k++) cnt[g][k] = '0;
          cnt[g][ro]     = count_t'(1);
          pend[g]        = 1'b0;
          live[g]        = 1'b1;
          e.result_block = BLK_W'(g);
          e.new_count    = CNT_W'(1);
        end
      end
    end else if (b >= POOL_SIZE) begin
      e.status = ST_BAD_ID;
    end else if (!live[b]) begin
      e.status = ST_UNALLOCATED;
    end else if (r.op == OP_ADD_REF) begin
      if (pend[b] && r.role != ROLE_EVICTOR) begin
        e.status = ST_PENDING;
      end else if (cnt[b][ro] == COUNT_MAX) begin
        e.status    = ST_SATURATED;
        e.new_count = CNT_W'(COUNT_MAX);
      end else begin
        cnt[b][ro]  = cnt[b][ro] + count_t'(1);
        e.new_count = CNT_W'(cnt[b][ro]);
      end
    end else if (r.op == OP_RELEASE) begin
      if (cnt[b][ro] == 0) begin
        e.status = ST_ALREADY_ZERO;
      end else begin
        cnt[b][ro]  = cnt[b][ro] - count_t'(1);
        e.new_count = CNT_W'(cnt[b][ro]);
        if (others_zero(b) && cnt[b][ROLE_EVICTOR] == 0) begin
          free_block(b);
          e.block_freed = 1'b1;
        end
      end
    end else begin
      pend[b] = 1'b1;
      if (others_zero(b)) begin
        free_block(b);
        e.block_freed = 1'b1;
      end else begin
        e.new_count = CNT_W'(cnt[b][ro]);
      end
    end
    expected_q.insert(expected_q.size(), e);
  endfunction

  function void check_response(out_rsp_t got);
    out_rsp_t e;
    if (expected_q.size() == 0) begin
      if (mismatches < 10) $display("unexpected response %p", got);
      mismatches++;
      return;
    end
    e = expected_q.pop_front();
    if (got.result_block !== e.result_block || got.new_count !== e.new_count ||
        got.status !== e.status || got.block_freed !== e.block_freed) begin
      if (mismatches < 10)
        $display("response mismatch: block %0d/%0d count %0d/%0d status %0d/%0d freed %0d/%0d",
                 e.result_block, got.result_block, e.new_count, got.new_count,
                 e.status, got.status, e.block_freed, got.block_freed);
      mismatches++;
    end
  endfunction
endclass

module tb_multi_role_refcount_block_pool;
  localparam int TOP = POOL_SIZE - 1;

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_rsp_t out_rsp_o;

  int idle_pct  = 8;
  int stall_pct = 81;

  refcount_scoreboard sb = new();

  multi_role_refcount_block_pool dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #16_000_000;
    $display("[multi_role_refcount_block_pool] ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);
  end

  task automatic send(input in_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic send_op(input op_e op, input int blk, input role_e ro);
    in_req_t r;
    r.op       = op;
    r.blk_addr = BLK_W'(blk);
    r.role     = ro;
    send(r);
  endtask

  function automatic int live_block();
    int start;
    int b;
    start = $urandom_range(POOL_SIZE - 1);
    for (int k = 0; k < POOL_SIZE; k++) begin
      b = (start + k) % POOL_SIZE;
      if (sb.live[b]) return b;
    end
    return -1;
  endfunction

  function automatic role_e held_role(int b, role_e dflt);
    int start;
    int ro;
    start = $urandom_range(NUM_ROLES - 1);
    for (int k = 0; k < NUM_ROLES; k++) begin
      ro = (start + k) % NUM_ROLES;
      if (sb.cnt[b][ro] != 0) return role_e'(ro);
    end
    return dflt;
  endfunction

  function automatic in_req_t gen_request(int alloc_pct);
    in_req_t r;
    int      pick;
    int      b;
    r.blk_addr = BLK_W'($urandom_range(255));
    r.role     = role_e'($urandom_range(NUM_ROLES - 1));
    r.op       = OP_ALLOC;
    if ($urandom_range(99) >= alloc_pct) begin
      pick = $urandom_range(99);
      if (pick < 40) r.op = OP_ADD_REF;
      else if (pick < 80) r.op = OP_RELEASE;
      else r.op = OP_MARK_PEND;
      if ($urandom_range(99) < 85) begin
        b = live_block();
        if (b >= 0) r.blk_addr = BLK_W'(b);
      end
      if (r.op == OP_RELEASE && $urandom_range(99) < 70 && r.blk_addr < POOL_SIZE)
        r.role = held_role(r.blk_addr, r.role);
    end
    return r;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send(gen_request(((i / 100) % 2) ? 55 : 15));
  endtask

  initial begin
    int k;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(OP_ADD_REF, 7, ROLE_DRAFT);
    send_op(OP_RELEASE, 7, ROLE_TARGET);
    send_op(OP_MARK_PEND, 7, ROLE_EVICTOR);
    send_op(OP_ALLOC, 0, ROLE_EVICTOR);
    send_op(OP_ALLOC, 255, ROLE_DRAFT);
    send_op(OP_ADD_REF, TOP, ROLE_TARGET);
    send_op(OP_ADD_REF, TOP, ROLE_EVICTOR);
    send_op(OP_RELEASE, TOP, ROLE_POLICY);
    send_op(OP_MARK_PEND, TOP, ROLE_TARGET);
    send_op(OP_ADD_REF, TOP, ROLE_DRAFT);
    send_op(OP_ADD_REF, TOP, ROLE_EVICTOR);
    send_op(OP_MARK_PEND, TOP, ROLE_EVICTOR);
    send_op(OP_RELEASE, TOP, ROLE_DRAFT);
    send_op(OP_RELEASE, TOP, ROLE_TARGET);
    send_op(OP_ALLOC, 0, ROLE_TARGET);
    send_op(OP_MARK_PEND, TOP - 1, ROLE_POLICY);
    send_op(OP_RELEASE, TOP - 1, ROLE_TARGET);
    send_op(OP_ALLOC, 0, ROLE_POLICY);
    send_op(OP_RELEASE, TOP - 1, ROLE_POLICY);
    send_op(OP_ALLOC, 0, ROLE_DRAFT);
    send_op(OP_ADD_REF, TOP - 1, ROLE_EVICTOR);
    send_op(OP_RELEASE, TOP - 1, ROLE_DRAFT);
    send_op(OP_MARK_PEND, TOP - 1, ROLE_EVICTOR);

    // drain the stack; the next allocate sweeps and reclaims the evictor-held block
    k = 0;
    while (sb.depth != 0) begin
      send_op(OP_ALLOC, $urandom_range(255), role_e'(k % 3));
      k++;
    end
    send_op(OP_ALLOC, 0, ROLE_DRAFT);
    send_op(OP_ALLOC, 0, ROLE_TARGET);

    run_random(300);
    idle_pct  = 81;
    stall_pct = 8;
    run_random(300);
    idle_pct  = 0;
    stall_pct = 0;
    run_random(200);
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("[multi_role_refcount_block_pool] OK");
    end else begin
      $display("[multi_role_refcount_block_pool] ERROR");
    end
    $finish;
  end
endmodule
